@@ rtl/rvdec_pkg.sv @@
// Types and constants for the RV32I instruction decoder.
// No dependencies.
`timescale 1ns / 1ps

package rvdec_pkg;

	// RV32I major opcodes, bits 6:0
	localparam logic [6:0] OPC_R_ALU  = 7'h33;
	localparam logic [6:0] OPC_I_ALU  = 7'h13;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_JAL    = 7'h6F;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_SYSTEM = 7'h73;

	// funct3 codes that need naming
	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	localparam logic [2:0] F3_PRIV   = 3'd0;
	localparam logic [2:0] F3_CSRRW  = 3'd1;
	localparam logic [2:0] F3_CSRRS  = 3'd2;
	localparam logic [2:0] F3_CSRRC  = 3'd3;
	localparam logic [2:0] F3_RSVD   = 3'd4;
	localparam logic [2:0] F3_CSRRWI = 3'd5;
	localparam logic [2:0] F3_CSRRSI = 3'd6;
	localparam logic [2:0] F3_CSRRCI = 3'd7;

	typedef enum logic [3:0] {
		CLS_UNKNOWN = 4'd0,
		CLS_R_ALU   = 4'd1,
		CLS_I_ALU   = 4'd2,
		CLS_LOAD    = 4'd3,
		CLS_STORE   = 4'd4,
		CLS_BRANCH  = 4'd5,
		CLS_JAL     = 4'd6,
		CLS_JALR    = 4'd7,
		CLS_LUI     = 4'd8,
		CLS_AUIPC   = 4'd9,
		CLS_CSR     = 4'd10
	} instr_class_t;

	typedef enum logic [3:0] {
		ALU_ADD  = 4'd0,
		ALU_SUB  = 4'd1,
		ALU_SLL  = 4'd2,
		ALU_SLTU = 4'd3,
		ALU_SRL  = 4'd4,
		ALU_XOR  = 4'd5,
		ALU_SLT  = 4'd6,
		ALU_SRA  = 4'd7,
		ALU_OR   = 4'd8,
		ALU_AND  = 4'd9
	} alu_code_t;

	typedef enum logic [2:0] {
		CSR_NONE   = 3'd0,
		CSR_RW     = 3'd1,
		CSR_RS     = 3'd2,
		CSR_RC     = 3'd3,
		CSR_RWI    = 3'd4,
		CSR_RSI    = 3'd5,
		CSR_RCI    = 3'd6
	} csr_action_t;

	// Fully decoded instruction
	typedef struct packed {
		instr_class_t      instr_class;
		alu_code_t         alu_code;
		logic [4:0]        src_reg_a;
		logic [4:0]        src_reg_b;
		logic [4:0]        dest_reg;
		logic signed [31:0] immediate;
		logic [2:0]        func_three;
		logic [11:0]       csr_address;
		csr_action_t       csr_action;
		logic              uses_alu;
		logic              has_immediate;
	} dec_t;

endpackage

@@ rtl/rvdec_core.sv @@
// Combinational RV32I decode: class, ALU code, immediate, CSR action, flags.
// Depends on rvdec_pkg.
`timescale 1ns / 1ps

module rvdec_core (
	input  logic [31:0]   instr_word,
	output rvdec_pkg::dec_t dec
);
	import rvdec_pkg::*;

	logic [6:0]  opc;
	logic [2:0]  f3;
	logic        alt;
	logic [31:0] imm_i;
	logic [31:0] imm_s;
	logic [31:0] imm_b;
	logic [31:0] imm_j;
	logic [31:0] imm_u;
	logic [31:0] imm_shamt;
	alu_code_t   alu_base;

	assign opc = instr_word[6:0];
	assign f3  = instr_word[14:12];
	assign alt = instr_word[30];

	assign imm_i = {{20{instr_word[31]}}, instr_word[31:20]};
	assign imm_s = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
	assign imm_b = {{19{instr_word[31]}}, instr_word[31], instr_word[7],
		instr_word[30:25], instr_word[11:8], 1'b0};
	assign imm_j = {{11{instr_word[31]}}, instr_word[31], instr_word[19:12],
		instr_word[20], instr_word[30:21], 1'b0};
	assign imm_u = {instr_word[31:12], 12'h000};
	assign imm_shamt = {27'd0, instr_word[24:20]};

	// shared R/I ALU mapping; add/sub split handled per class
	always_comb begin
		unique case (f3)
			F3_ADD:  alu_base = ALU_ADD;
			F3_SLL:  alu_base = ALU_SLL;
			F3_SLT:  alu_base = ALU_SLT;
			F3_SLTU: alu_base = ALU_SLTU;
			F3_XOR:  alu_base = ALU_XOR;
			F3_SR:   alu_base = alt ? ALU_SRA : ALU_SRL;
			F3_OR:   alu_base = ALU_OR;
			F3_AND:  alu_base = ALU_AND;
			default: alu_base = ALU_ADD;
		endcase
	end

	always_comb begin
		dec.instr_class   = CLS_UNKNOWN;
		dec.alu_code      = ALU_ADD;
		dec.src_reg_a     = instr_word[19:15];
		dec.src_reg_b     = instr_word[24:20];
		dec.dest_reg      = instr_word[11:7];
		dec.immediate     = '0;
		dec.func_three    = f3;
		dec.csr_address   = instr_word[31:20];
		dec.csr_action    = CSR_NONE;
		dec.uses_alu      = 1'b0;
		dec.has_immediate = 1'b0;

		unique case (opc)
			OPC_R_ALU: begin
				dec.instr_class = CLS_R_ALU;
				dec.alu_code    = (f3 == F3_ADD && alt) ? ALU_SUB : alu_base;
				dec.uses_alu    = 1'b1;
			end
			OPC_I_ALU: begin
				dec.instr_class   = CLS_I_ALU;
				dec.alu_code      = alu_base;
				dec.immediate     = (f3 == F3_SLL || f3 == F3_SR) ? imm_shamt : imm_i;
				dec.uses_alu      = 1'b1;
				dec.has_immediate = 1'b1;
			end
			OPC_LOAD: begin
				dec.instr_class   = CLS_LOAD;
				dec.immediate     = imm_i;
				dec.uses_alu      = 1'b1;
				dec.has_immediate = 1'b1;
			end
			OPC_STORE: begin
				dec.instr_class   = CLS_STORE;
				dec.immediate     = imm_s;
				dec.uses_alu      = 1'b1;
				dec.has_immediate = 1'b1;
			end
			OPC_BRANCH: begin
				dec.instr_class   = CLS_BRANCH;
				dec.immediate     = imm_b;
				dec.uses_alu      = 1'b1;
				dec.has_immediate = 1'b1;
				case (f3)
					F3_BEQ, F3_BNE:   dec.alu_code = ALU_SUB;
					F3_BLT, F3_BGE:   dec.alu_code = ALU_SLT;
					F3_BLTU, F3_BGEU: dec.alu_code = ALU_SLTU;
					default:          dec.alu_code = ALU_ADD;
				endcase
			end
			OPC_JAL: begin
				dec.instr_class   = CLS_JAL;
				dec.immediate     = imm_j;
				dec.has_immediate = 1'b1;
			end
			OPC_JALR: begin
				dec.instr_class   = CLS_JALR;
				dec.immediate     = imm_i;
				dec.has_immediate = 1'b1;
			end
			OPC_LUI: begin
				dec.instr_class   = CLS_LUI;
				dec.immediate     = imm_u;
				dec.has_immediate = 1'b1;
			end
			OPC_AUIPC: begin
				dec.instr_class   = CLS_AUIPC;
				dec.immediate     = imm_u;
				dec.has_immediate = 1'b1;
			end
			OPC_SYSTEM: begin
				dec.instr_class = CLS_CSR;
				unique case (f3)
					F3_CSRRW:  dec.csr_action = CSR_RW;
					F3_CSRRS:  dec.csr_action = CSR_RS;
					F3_CSRRC:  dec.csr_action = CSR_RC;
					F3_CSRRWI: dec.csr_action = CSR_RWI;
					F3_CSRRSI: dec.csr_action = CSR_RSI;
					F3_CSRRCI: dec.csr_action = CSR_RCI;
					F3_PRIV, F3_RSVD: dec.csr_action = CSR_NONE;
					default:   dec.csr_action = CSR_NONE;
				endcase
			end
			default: begin
				dec.instr_class = CLS_UNKNOWN;
			end
		endcase
	end

endmodule

@@ rtl/rv32i_instruction_decoder_top.sv @@
// RV32I instruction decoder, top level: input register, decode, result register.
// A transferred word is held in the input register, decoded, and registered
// again in the result register, which drives the result ports with done high. Throughput: one
// word per cycle; busy is never raised, since the receiver cannot stall results.
// Reset (arst_n low, asynchronous) clears the stage valids; payload is not reset.
// Depends on rvdec_pkg and rvdec_core.
`timescale 1ns / 1ps

module rv32i_instruction_decoder_top (
	input  logic                       clk,
	input  logic                       arst_n,
	// command side
	input  logic                       start,
	output logic                       busy,
	input  logic [31:0]                instr_word,
	// result side, done high for a single cycle per result
	output logic                       done,
	output rvdec_pkg::instr_class_t    instr_class,
	output rvdec_pkg::alu_code_t       alu_code,
	output logic [4:0]                 src_reg_a,
	output logic [4:0]                 src_reg_b,
	output logic [4:0]                 dest_reg,
	output logic signed [31:0]         immediate,
	output logic [2:0]                 func_three,
	output logic [11:0]                csr_address,
	output rvdec_pkg::csr_action_t     csr_action,
	output logic                       uses_alu,
	output logic                       has_immediate
);
	import rvdec_pkg::*;

	// Stage 1: captured instruction word
	logic        valid_s1;
	logic [31:0] instr_s1;

	// Stage 2: decoded result, drives the ports directly
	logic        valid_s2;
	dec_t        dec_s2;

	dec_t        dec_comb;

	// Decoder never stalls: every start is a transfer.
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	// Payload registers load only on a transfer; no reset needed.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			instr_s1 <= instr_word;
		end
		if (valid_s1) begin
			dec_s2 <= dec_comb;
		end
	end

	rvdec_core u_core (
		.instr_word (instr_s1),
		.dec        (dec_comb)
	);

	assign done          = valid_s2;
	assign instr_class   = dec_s2.instr_class;
	assign alu_code      = dec_s2.alu_code;
	assign src_reg_a     = dec_s2.src_reg_a;
	assign src_reg_b     = dec_s2.src_reg_b;
	assign dest_reg      = dec_s2.dest_reg;
	assign immediate     = dec_s2.immediate;
	assign func_three    = dec_s2.func_three;
	assign csr_address   = dec_s2.csr_address;
	assign csr_action    = dec_s2.csr_action;
	assign uses_alu      = dec_s2.uses_alu;
	assign has_immediate = dec_s2.has_immediate;

endmodule

@@ dv/tb_rv32i_instruction_decoder_top.sv @@
// Testbench for rv32i_instruction_decoder_top: directed and random instruction words,
// each decode predicted in the bench and checked field by field against the result ports.
// Depends on rvdec_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_rv32i_instruction_decoder_top;
	import rvdec_pkg::*;

	// Run limit in clock cycles.
	localparam int unsigned CYCLE_LIMIT = 200000;
	// Cycles run on after every expected result has been checked.
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned RANDOM_PER_PHASE = 490;

	// One instruction word waiting to be sent, with the chance (in percent)
	// that the sender sits idle on any cycle while it is at the head.
	typedef struct {
		logic [31:0] word;
		int unsigned idle_pct;
	} fetch_item_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [31:0]        instr_word;
	logic               done;
	instr_class_t       instr_class;
	alu_code_t          alu_code;
	logic [4:0]         src_reg_a;
	logic [4:0]         src_reg_b;
	logic [4:0]         dest_reg;
	logic signed [31:0] immediate;
	logic [2:0]         func_three;
	logic [11:0]        csr_address;
	csr_action_t        csr_action;
	logic               uses_alu;
	logic               has_immediate;

	fetch_item_t fetch_q[$];      // words still to be sent
	dec_t        pending_decodes[$]; // predicted decodes not yet seen on the outputs
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;

	rv32i_instruction_decoder_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.instr_word    (instr_word),
		.done          (done),
		.instr_class   (instr_class),
		.alu_code      (alu_code),
		.src_reg_a     (src_reg_a),
		.src_reg_b     (src_reg_b),
		.dest_reg      (dest_reg),
		.immediate     (immediate),
		.func_three    (func_three),
		.csr_address   (csr_address),
		.csr_action    (csr_action),
		.uses_alu      (uses_alu),
		.has_immediate (has_immediate)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Bench model of the decoder: class from the opcode, ALU code from funct3
	// and bit 30, immediate in the format of the class, raw fields passed on.
	function automatic dec_t decode_word(input logic [31:0] w);
		dec_t       d;
		logic [2:0] f3;
		logic       alt;
		logic [31:0] imm_i;
		d   = '0;
		f3  = w[14:12];
		alt = w[30];
		imm_i = {{20{w[31]}}, w[31:20]};

		d.src_reg_a   = w[19:15];
		d.src_reg_b   = w[24:20];
		d.dest_reg    = w[11:7];
		d.func_three  = f3;
		d.csr_address = w[31:20];

		case (w[6:0])
			OPC_R_ALU:  d.instr_class = CLS_R_ALU;
			OPC_I_ALU:  d.instr_class = CLS_I_ALU;
			OPC_LOAD:   d.instr_class = CLS_LOAD;
			OPC_STORE:  d.instr_class = CLS_STORE;
			OPC_BRANCH: d.instr_class = CLS_BRANCH;
			OPC_JAL:    d.instr_class = CLS_JAL;
			OPC_JALR:   d.instr_class = CLS_JALR;
			OPC_LUI:    d.instr_class = CLS_LUI;
			OPC_AUIPC:  d.instr_class = CLS_AUIPC;
			OPC_SYSTEM: d.instr_class = CLS_CSR;
			default:    d.instr_class = CLS_UNKNOWN;
		endcase

		// ALU operation
		d.alu_code = ALU_ADD;
		if (d.instr_class == CLS_R_ALU || d.instr_class == CLS_I_ALU) begin
			case (f3)
				F3_ADD:  d.alu_code = (d.instr_class == CLS_R_ALU && alt) ? ALU_SUB : ALU_ADD;
				F3_SLL:  d.alu_code = ALU_SLL;
				F3_SLT:  d.alu_code = ALU_SLT;
				F3_SLTU: d.alu_code = ALU_SLTU;
				F3_XOR:  d.alu_code = ALU_XOR;
				F3_SR:   d.alu_code = alt ? ALU_SRA : ALU_SRL;
				F3_OR:   d.alu_code = ALU_OR;
				default: d.alu_code = ALU_AND;
			endcase
		end else if (d.instr_class == CLS_BRANCH) begin
			case (f3)
				F3_BEQ, F3_BNE:   d.alu_code = ALU_SUB;
				F3_BLT, F3_BGE:   d.alu_code = ALU_SLT;
				F3_BLTU, F3_BGEU: d.alu_code = ALU_SLTU;
				default:          d.alu_code = ALU_ADD;
			endcase
		end

		// Immediate; shift amount only for the I-type ALU shifts
		case (d.instr_class)
			CLS_LUI, CLS_AUIPC: d.immediate = {w[31:12], 12'b0};
			CLS_I_ALU:          d.immediate = (f3 == F3_SLL || f3 == F3_SR) ?
			                                  {27'b0, w[24:20]} : imm_i;
			CLS_LOAD, CLS_JALR: d.immediate = imm_i;
			CLS_STORE:          d.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
			CLS_BRANCH:         d.immediate = {{19{w[31]}}, w[31], w[7], w[30:25],
			                                   w[11:8], 1'b0};
			CLS_JAL:            d.immediate = {{11{w[31]}}, w[31], w[19:12], w[20],
			                                   w[30:21], 1'b0};
			default:            d.immediate = '0;
		endcase

		// CSR operation; privileged and reserved funct3 stay class csr, action none
		d.csr_action = CSR_NONE;
		if (d.instr_class == CLS_CSR) begin
			case (f3)
				F3_CSRRW:  d.csr_action = CSR_RW;
				F3_CSRRS:  d.csr_action = CSR_RS;
				F3_CSRRC:  d.csr_action = CSR_RC;
				F3_CSRRWI: d.csr_action = CSR_RWI;
				F3_CSRRSI: d.csr_action = CSR_RSI;
				F3_CSRRCI: d.csr_action = CSR_RCI;
				default:   d.csr_action = CSR_NONE;
			endcase
		end

		case (d.instr_class)
			CLS_R_ALU, CLS_I_ALU, CLS_LOAD, CLS_STORE, CLS_BRANCH: d.uses_alu = 1'b1;
			default: d.uses_alu = 1'b0;
		endcase
		case (d.instr_class)
			CLS_I_ALU, CLS_LOAD, CLS_STORE, CLS_BRANCH, CLS_JAL, CLS_JALR,
			CLS_LUI, CLS_AUIPC: d.has_immediate = 1'b1;
			default: d.has_immediate = 1'b0;
		endcase
		return d;
	endfunction

	// Assemble a word from the R-type field split: funct7, rs2, rs1, funct3, rd, opcode.
	function automatic logic [31:0] form_word(input logic [6:0] hi7, input logic [4:0] rs2,
		input logic [4:0] rs1, input logic [2:0] f3, input logic [4:0] rd,
		input logic [6:0] opc);
		return {hi7, rs2, rs1, f3, rd, opc};
	endfunction

	task automatic queue_word(input logic [31:0] w, input int unsigned pct);
		fetch_item_t it;
		it.word     = w;
		it.idle_pct = pct;
		fetch_q = {fetch_q, it};
	endtask

	task automatic check_field(input string label, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, label, want, got);
			error_count++;
		end
	endtask

	// Driver: changes inputs on the falling edge. The head of fetch_q is offered
	// until a transfer takes it; idle cycles put noise on the word with start low.
	always @(negedge clk) begin
		if (!arst_n || fetch_q.size() == 0) begin
			start      <= 1'b0;
			instr_word <= $urandom;
		end else if ($urandom_range(99) < fetch_q[0].idle_pct) begin
			start      <= 1'b0;
			instr_word <= $urandom;
		end else begin
			start      <= 1'b1;
			instr_word <= fetch_q[0].word;
		end
	end

	// Monitor: samples on the rising edge. The result strobe is checked first;
	// a transfer on the same edge cannot be the source of that result.
	always @(posedge clk) begin
		dec_t want;
		if (arst_n) begin
			if (done === 1'b1) begin
				if (pending_decodes.size() == 0) begin
					$display("%0t ns: result with nothing expected, expected none, actual %h",
						$time, instr_class);
					error_count++;
				end else begin
					want = pending_decodes.pop_front();
					check_field("instr_class",   32'(want.instr_class),   32'(instr_class));
					check_field("alu_code",      32'(want.alu_code),      32'(alu_code));
					check_field("src_reg_a",     32'(want.src_reg_a),     32'(src_reg_a));
					check_field("src_reg_b",     32'(want.src_reg_b),     32'(src_reg_b));
					check_field("dest_reg",      32'(want.dest_reg),      32'(dest_reg));
					check_field("immediate",     want.immediate,          immediate);
					check_field("func_three",    32'(want.func_three),    32'(func_three));
					check_field("csr_address",   32'(want.csr_address),   32'(csr_address));
					check_field("csr_action",    32'(want.csr_action),    32'(csr_action));
					check_field("uses_alu",      32'(want.uses_alu),      32'(uses_alu));
					check_field("has_immediate", 32'(want.has_immediate),
						32'(has_immediate));
				end
			end
			// transfer: predict its decode and retire the word from the send queue
			if (start === 1'b1 && busy === 1'b0 && fetch_q.size() != 0) begin
				pending_decodes = {pending_decodes, decode_word(instr_word)};
				void'(fetch_q.pop_front());
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_rv32i_instruction_decoder_top: done, errors");
			$finish;
		end
	end

	initial begin
		logic [6:0]  valid_opc [10];
		int unsigned phase_pct [4];
		logic [31:0] w;
		valid_opc = '{OPC_R_ALU, OPC_I_ALU, OPC_LOAD, OPC_STORE, OPC_BRANCH,
		              OPC_JAL, OPC_JALR, OPC_LUI, OPC_AUIPC, OPC_SYSTEM};
		// Sender idling per phase: none, heavy, light, none again.
		phase_pct = '{0, 45, 15, 0};

		arst_n     = 1'b0;

		// Directed part, sent back to back.
		queue_word(32'h0000_0000, 0);                                     // all zero, unknown
		queue_word(32'hFFFF_FFFF, 0);                                     // all ones, unknown
		queue_word(form_word(7'h00, 5'd0, 5'd0, F3_ADD, 5'd0, OPC_R_ALU), 0);    // add
		queue_word(form_word(7'h20, 5'd31, 5'd31, F3_ADD, 5'd31, OPC_R_ALU), 0); // sub
		queue_word(form_word(7'h00, 5'd5, 5'd6, F3_SR, 5'd7, OPC_R_ALU), 0);     // srl
		queue_word(form_word(7'h7F, 5'd9, 5'd1, F3_SR, 5'd2, OPC_R_ALU), 0);     // sra, stray bits
		// shifts take the bare shift amount, even with the top bits set
		queue_word(form_word(7'h7F, 5'd31, 5'd1, F3_SR, 5'd2, OPC_I_ALU), 0);    // srai
		queue_word(form_word(7'h7F, 5'd31, 5'd0, F3_SLL, 5'd0, OPC_I_ALU), 0);   // slli
		// addi with bit 31 set and bit 30 clear; most negative I immediate
		queue_word(form_word(7'h40, 5'd0, 5'd3, F3_ADD, 5'd4, OPC_I_ALU), 0);
		queue_word(form_word(7'h3F, 5'd31, 5'd3, F3_SLTU, 5'd4, OPC_I_ALU), 0);  // largest positive
		// loads with shift funct3 keep the full I immediate
		queue_word(form_word(7'h7F, 5'd31, 5'd1, F3_SLL, 5'd1, OPC_LOAD), 0);
		queue_word(form_word(7'h40, 5'd0, 5'd2, F3_SLT, 5'd31, OPC_STORE), 0);
		// every branch funct3, including the two undefined ones
		for (int f = 0; f < 8; f++)
			queue_word(form_word((f % 2) ? 7'h7F : 7'h40, 5'(f), 5'(31 - f), 3'(f),
				(f % 2) ? 5'd31 : 5'd0, OPC_BRANCH), 0);
		queue_word(form_word(7'h7F, 5'd31, 5'd31, 3'd7, 5'd31, OPC_JAL), 0);     // jal, -2
		queue_word(form_word(7'h40, 5'd0, 5'd0, 3'd0, 5'd0, OPC_JAL), 0);        // jal, most negative
		queue_word(form_word(7'h40, 5'd0, 5'd10, 3'd0, 5'd1, OPC_JALR), 0);
		queue_word(form_word(7'h7F, 5'd31, 5'd31, 3'd7, 5'd0, OPC_LUI), 0);
		queue_word(form_word(7'h40, 5'd0, 5'd0, 3'd0, 5'd31, OPC_AUIPC), 0);
		// every system funct3: privileged and reserved give no csr action
		for (int f = 0; f < 8; f++)
			queue_word(form_word((f % 2) ? 7'h7F : 7'h00, (f % 2) ? 5'd31 : 5'd0,
				5'(f * 3), 3'(f), 5'(f), OPC_SYSTEM), 0);

		// Random part: mostly valid opcodes with random fields, some raw noise.
		for (int p = 0; p < 4; p++) begin
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				w = $urandom;
				if ($urandom_range(9) != 0)
					w[6:0] = valid_opc[$urandom_range(9)];
				queue_word(w, phase_pct[p]);
			end
		end

		// Reset is released on a falling edge.
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (fetch_q.size() != 0 || pending_decodes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("tb_rv32i_instruction_decoder_top: done, clean");
		else
			$display("tb_rv32i_instruction_decoder_top: done, errors");
		$finish;
	end

endmodule
